// ===== rtl/qedec_pkg.sv =====
// ----------------------------------------------------------------------------
// qedec_pkg
// Types, codes and the quadrature step table shared by the decoder files.
// ----------------------------------------------------------------------------
package qedec_pkg;

  typedef enum logic [1:0] {
    OP_WHEEL = 2'd0,
    OP_CLICK = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EVT_RIGHT      = 2'd0,
    EVT_LEFT       = 2'd1,
    EVT_CLICK_DOWN = 2'd2,
    EVT_CLICK_UP   = 2'd3
  } evt_t;

  localparam logic [7:0] TIMEOUT_RST = 8'd255;

  // step per {previous pins, new pins}; pins are {B, A}
  localparam logic signed [1:0] QUAD_STEPS [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic [1:0] opcode;
    logic       pin_a;
    logic       pin_b;
    logic       click_level;
  } item_t;

  // registered input item as seen by the core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // result pushed from the core into the output register
  typedef struct packed {
    logic       push;
    evt_t       event_code;
    logic [7:0] elapsed_ticks;
  } result_t;

endpackage

// ===== rtl/qedec_if.sv =====
// ----------------------------------------------------------------------------
// qedec_in_if / qedec_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface qedec_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       pin_a;
  logic       pin_b;
  logic       click_level;

  modport source (output valid, output opcode, output pin_a, output pin_b,
                  output click_level, input ready);
  modport sink   (input valid, input opcode, input pin_a, input pin_b,
                  input click_level, output ready);
endinterface

interface qedec_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic [7:0] elapsed_ticks;

  modport source (output valid, output event_code, output elapsed_ticks, input ready);
  modport sink   (input valid, input event_code, input elapsed_ticks, output ready);
endinterface

// ===== rtl/qedec_in_stage.sv =====
// ----------------------------------------------------------------------------
// qedec_in_stage
// Input register: holds one accepted beat until the core takes it.
// ----------------------------------------------------------------------------
module qedec_in_stage
  import qedec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  qedec_in_if.sink    in_ch,
  input  logic        take,
  output stage_t      stage
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{opcode: in_ch.opcode, pin_a: in_ch.pin_a, pin_b: in_ch.pin_b,
                  click_level: in_ch.click_level};
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== rtl/qedec_core.sv =====
// ----------------------------------------------------------------------------
// qedec_core
// Decoder state, quadrature lookup, step accumulation and event decode.
// ----------------------------------------------------------------------------
module qedec_core
  import qedec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  stage_t      stage,
  input  logic        out_free,
  output logic        take,
  output result_t     result
);

  logic [7:0]        timeout_r;
  logic [1:0]        prev_pins_r, prev_pins_nxt;
  logic signed [2:0] acc_r, acc_nxt;
  logic [7:0]        ticks_r, ticks_nxt;

  logic [1:0]        now_pins;
  logic signed [2:0] acc_sum;
  logic              has_res;
  evt_t              evt;
  logic [7:0]        evt_ticks;

  assign now_pins = {stage.item.pin_b, stage.item.pin_a};
  assign acc_sum  = acc_r + 3'(QUAD_STEPS[{prev_pins_r, now_pins}]);

  always_comb begin
    prev_pins_nxt = prev_pins_r;
    acc_nxt       = acc_r;
    ticks_nxt     = ticks_r;
    has_res       = 1'b0;
    evt           = EVT_CLICK_UP;
    evt_ticks     = '0;
    unique case (stage.item.opcode)
      OP_WHEEL: begin
        prev_pins_nxt = now_pins;
        acc_nxt       = acc_sum;
        // reaching +3 or -3 fires and clears
        if (acc_sum == 3'sd3 || acc_sum == -3'sd3) begin
          has_res   = 1'b1;
          evt       = (acc_sum == 3'sd3) ? EVT_RIGHT : EVT_LEFT;
          evt_ticks = ticks_r;
          acc_nxt   = '0;
          ticks_nxt = '0;
        end
      end
      OP_CLICK: begin
        has_res = 1'b1;
        evt     = stage.item.click_level ? EVT_CLICK_DOWN : EVT_CLICK_UP;
      end
      OP_TICK: begin
        if (ticks_r < timeout_r) begin
          ticks_nxt = ticks_r + 8'd1;
        end
      end
      default: ;
    endcase
  end

  assign take                 = stage.valid && (!has_res || out_free);
  assign result.push          = take && has_res;
  assign result.event_code    = evt;
  assign result.elapsed_ticks = evt_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r <= '0;
      acc_r       <= '0;
      ticks_r     <= '0;
    end else if (take) begin
      prev_pins_r <= prev_pins_nxt;
      acc_r       <= acc_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

endmodule

// ===== rtl/qedec_out_stage.sv =====
// ----------------------------------------------------------------------------
// qedec_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module qedec_out_stage
  import qedec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  result_t     result,
  output logic        out_free,
  qedec_out_if.source out_ch
);

  logic       valid_r, valid_nxt;
  logic [1:0] code_r;
  logic [7:0] ticks_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (result.push) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.push) begin
      code_r  <= result.event_code;
      ticks_r <= result.elapsed_ticks;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.event_code    = code_r;
  assign out_ch.elapsed_ticks = ticks_r;

endmodule

// ===== rtl/quadrature_encoder_event_decoder.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_event_decoder
// Turns wheel, click and tick beats into rotation and click events.
// ----------------------------------------------------------------------------
// in_ch carries one item per beat: a wheel sample (pin_a, pin_b), a click
// sample (click_level) or a timer tick; opcode 3 is dropped silently.
// out_ch carries events: right/left with the ticks since the last rotation
// event, click down/up with elapsed_ticks of 0. Wheel and tick beats that
// do not complete a rotation produce no result beat.
// cfg_we/cfg_wdata set the tick limit, the ceiling of the tick counter;
// write it only while the block is idle.
// An accepted beat passes from the input register through the core into
// the result register. Throughput is one beat per cycle while out_ch does
// not stall, set by the single lookup-and-add between the two registers.
// When out_ch stalls, the result register holds; beats with no result still
// flow, and the first beat that needs the output waits in the input
// register, which then drops in_ch.ready.
// Synchronous reset clears both registers' valids, the pin history, the
// step accumulator and the tick counter, and sets the tick limit to 255.
// ----------------------------------------------------------------------------
module quadrature_encoder_event_decoder
  import qedec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  qedec_in_if.sink    in_ch,
  qedec_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  stage_t  stage;
  result_t result;
  logic    take;
  logic    out_free;

  qedec_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  qedec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .out_free  (out_free),
    .take      (take),
    .result    (result)
  );

  qedec_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  // input register must be full whenever it refuses a beat
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> stage.valid)
    else $error("in_ch.ready low with empty input register");

  // an item waiting on the output stays put
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && !take) |=> (stage.valid && $stable(stage.item)))
    else $error("held input item changed");

  // a pushed result shows up on out_ch the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    result.push |=> (out_ch.valid && out_ch.event_code == $past(result.event_code)))
    else $error("pushed result missing on out_ch");

  // click events never carry a tick count
  a_click_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.event_code == EVT_CLICK_DOWN ||
                      out_ch.event_code == EVT_CLICK_UP))
      |-> (out_ch.elapsed_ticks == 8'd0))
    else $error("click event with nonzero elapsed_ticks");

endmodule
